/* hw/rtl/dst_pkg.sv */
// Shared types and constants of the insertion-ordered set table.
`default_nettype none

package dst_pkg;

  // Default number of entries in the set memory.
  localparam int DST_DEPTH = 16;

  // Widths fixed by the word formats.
  localparam int CAP_W   = 5;
  localparam int COUNT_W = 5;
  localparam int VALUE_W = 32;

  // Capacity limit after reset.
  localparam logic [CAP_W-1:0] CAP_RESET = CAP_W'(16);

  // Operation codes; the fourth code behaves as a lookup.
  typedef enum logic [1:0] {
    CMD_INSERT = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_LOOKUP = 2'd2
  } cmd_code_t;

  typedef struct packed {
    logic [1:0]                cmd;
    logic signed [VALUE_W-1:0] element_value;
  } req_word_t;

  typedef struct packed {
    logic               was_present;
    logic               full_reject;
    logic [COUNT_W-1:0] entry_count;
    logic               set_empty;
  } rsp_word_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load_req;    // latch the request, restart the index
    logic rd_en;       // read the entry memory
    logic rd_next;     // read at index + 1 instead of index
    logic inc_idx;     // step the index
    logic set_found;   // record a match at the current index
    logic wr_insert;   // append the request value
    logic inc_count;
    logic wr_shift;    // move the read entry down to the index
    logic dec_count;
    logic set_reject;
    logic load_rsp;    // capture the result word
  } dst_ctl_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic at_end;      // index has reached the entry count
    logic shift_end;   // no entry above the index is left to move
    logic match;       // registered read data equals the request value
    logic found;
    logic can_insert;
    logic is_insert;
    logic is_remove;
  } dst_stat_t;

endpackage

`default_nettype wire

/* hw/rtl/dedup_set_table_top.sv */
// Top level of the insertion-ordered set table without duplicates.
//
//   Channel  Signals                      Direction  Contents
//   req      req_valid/req_ready/req_word  in         operation code and value
//   rsp      rsp_valid/rsp_ready/rsp_word  out        presence, reject, count, empty
//   cfg      cfg_we/cfg_wdata              in         capacity limit, written at once
//
// A request word is taken while the block is idle, and the held entries are then compared
// one after another, each read in the scan state and checked in the compare state; a match
// or the end of the entries leads to the update state and then to the result capture. A
// removal adds a read and a write state for every entry above the removed one that moves down.
// Reset is synchronous; it empties the set and restores the capacity limit to 16.
// A held result word never blocks the next request word; the block stalls only when a
// new result is ready and the previous one has not been taken.
`default_nettype none

module dedup_set_table_top
  import dst_pkg::*;
#(
  parameter int SET_DEPTH = DST_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire logic             req_valid,
  output logic                  req_ready,
  input  wire req_word_t        req_word,
  output logic                  rsp_valid,
  input  wire logic             rsp_ready,
  output rsp_word_t             rsp_word
);

  // Commands and status between the sequencer and the datapath.
  dst_ctl_t  ctl;
  dst_stat_t stat;

  dst_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_ready (req_ready),
    .rsp_valid (rsp_valid),
    .rsp_ready (rsp_ready),
    .stat      (stat),
    .ctl       (ctl)
  );

  // The datapath holds the entries in a memory, so an absent entry is never read
  // before it was written and no clearing pass is needed after reset.
  dst_datapath #(
    .SET_DEPTH (SET_DEPTH)
  ) u_datapath (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_wdata (cfg_wdata),
    .req_word  (req_word),
    .ctl       (ctl),
    .stat      (stat),
    .rsp_word  (rsp_word)
  );

`ifndef NO_ASSERTIONS
  // A rejected insert is always one of a value that was not already held.
  assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> !(rsp_word.full_reject && rsp_word.was_present))
    else $error("full_reject raised for a value that was present");

  // The memory is never written while the block waits for a request word.
  assert property (@(posedge clk) disable iff (rst)
    req_ready |-> !(ctl.wr_insert || ctl.wr_shift))
    else $error("entry memory written while idle");

  // An append only happens for an insert whose value was not found.
  assert property (@(posedge clk) disable iff (rst)
    ctl.wr_insert |-> (stat.is_insert && !stat.found && stat.can_insert))
    else $error("append issued without a free slot or for a held value");

  // After a match the next step never advances the scan past it.
  assert property (@(posedge clk) disable iff (rst)
    ctl.set_found |=> !ctl.rd_en && !ctl.inc_idx)
    else $error("scan continued after a match");
`endif

endmodule

`default_nettype wire

/* hw/rtl/dst_datapath.sv */
// Datapath of the set table: entry memory, index, count and result register.
`default_nettype none

module dst_datapath
  import dst_pkg::*;
#(
  parameter int SET_DEPTH = DST_DEPTH
) (
  input  wire logic             clk,
  input  wire logic             rst,
  input  wire logic             cfg_we,
  input  wire logic [CAP_W-1:0] cfg_wdata,
  input  wire req_word_t        req_word,
  input  wire dst_ctl_t         ctl,
  output dst_stat_t             stat,
  output rsp_word_t             rsp_word
);

  localparam int IW   = (SET_DEPTH > 1) ? $clog2(SET_DEPTH) : 1;
  localparam int CW   = $clog2(SET_DEPTH + 1);
  localparam int CMPW = (CW > CAP_W) ? CW : CAP_W;

  logic [VALUE_W-1:0] mem [SET_DEPTH];
  logic [VALUE_W-1:0] rdata;

  req_word_t         cur;
  logic [CW-1:0]     idx;
  logic [CW-1:0]     count;
  logic [CAP_W-1:0]  cap;
  logic              found;
  logic              reject;

  logic [CW:0]       idx_plus;
  logic [CW-1:0]     rd_ptr;
  logic [IW-1:0]     rd_addr;

  assign idx_plus = {1'b0, idx} + (CW+1)'(1);
  assign rd_ptr   = ctl.rd_next ? idx_plus[CW-1:0] : idx;
  assign rd_addr  = rd_ptr[IW-1:0];

  // Entry memory: one write port, one registered read port.
  always_ff @(posedge clk) begin
    if (ctl.wr_insert) begin
      mem[count[IW-1:0]] <= cur.element_value;
    end else if (ctl.wr_shift) begin
      mem[idx[IW-1:0]] <= rdata;
    end
    if (ctl.rd_en) begin
      rdata <= mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count <= '0;
      cap   <= CAP_RESET;
    end else begin
      if (cfg_we) begin
        cap <= cfg_wdata;
      end
      if (ctl.inc_count) begin
        count <= count + CW'(1);
      end else if (ctl.dec_count) begin
        count <= count - CW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load_req) begin
      cur    <= req_word;
      idx    <= '0;
      found  <= 1'b0;
      reject <= 1'b0;
    end else begin
      if (ctl.inc_idx) begin
        idx <= idx + CW'(1);
      end
      if (ctl.set_found) begin
        found <= 1'b1;
      end
      if (ctl.set_reject) begin
        reject <= 1'b1;
      end
    end
    if (ctl.load_rsp) begin
      rsp_word.was_present <= found;
      rsp_word.full_reject <= reject;
      rsp_word.entry_count <= COUNT_W'(count);
      rsp_word.set_empty   <= (count == '0);
    end
  end

  always_comb begin
    stat.at_end     = (idx == count);
    stat.shift_end  = (idx_plus >= {1'b0, count});
    stat.match      = (rdata == VALUE_W'(cur.element_value));
    stat.found      = found;
    stat.can_insert = (CMPW'(count) < CMPW'(cap)) && (count < CW'(SET_DEPTH));
    stat.is_insert  = (cur.cmd == CMD_INSERT);
    stat.is_remove  = (cur.cmd == CMD_REMOVE);
  end

endmodule

`default_nettype wire

/* hw/rtl/dst_ctrl.sv */
// Controller of the set table: sequences scan, update, shift and result.
`default_nettype none

module dst_ctrl
  import dst_pkg::*;
(
  input  wire logic      clk,
  input  wire logic      rst,
  input  wire logic      req_valid,
  output logic           req_ready,
  output logic           rsp_valid,
  input  wire logic      rsp_ready,
  input  wire dst_stat_t stat,
  output dst_ctl_t       ctl
);

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_SCAN,
    ST_CMP,
    ST_EXEC,
    ST_SHIFT_RD,
    ST_SHIFT_WR,
    ST_RESULT
  } state_t;

  state_t state;
  state_t state_next;
  logic   slot_free;

  assign req_ready = (state == ST_IDLE);
  assign slot_free = !rsp_valid || rsp_ready;

  always_comb begin
    ctl        = '0;
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_valid) begin
          ctl.load_req = 1'b1;
          state_next   = ST_SCAN;
        end
      end
      ST_SCAN: begin
        if (stat.at_end) begin
          state_next = ST_EXEC;
        end else begin
          ctl.rd_en  = 1'b1;
          state_next = ST_CMP;
        end
      end
      ST_CMP: begin
        if (stat.match) begin
          ctl.set_found = 1'b1;
          state_next    = ST_EXEC;
        end else begin
          ctl.inc_idx = 1'b1;
          state_next  = ST_SCAN;
        end
      end
      ST_EXEC: begin
        state_next = ST_RESULT;
        if (stat.is_insert && !stat.found) begin
          if (stat.can_insert) begin
            ctl.wr_insert = 1'b1;
            ctl.inc_count = 1'b1;
          end else begin
            ctl.set_reject = 1'b1;
          end
        end else if (stat.is_remove && stat.found) begin
          state_next = ST_SHIFT_RD;
        end
      end
      ST_SHIFT_RD: begin
        if (stat.shift_end) begin
          ctl.dec_count = 1'b1;
          state_next    = ST_RESULT;
        end else begin
          ctl.rd_en   = 1'b1;
          ctl.rd_next = 1'b1;
          state_next  = ST_SHIFT_WR;
        end
      end
      ST_SHIFT_WR: begin
        ctl.wr_shift = 1'b1;
        ctl.inc_idx  = 1'b1;
        state_next   = ST_SHIFT_RD;
      end
      ST_RESULT: begin
        if (slot_free) begin
          ctl.load_rsp = 1'b1;
          state_next   = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (ctl.load_rsp) begin
        rsp_valid <= 1'b1;
      end else if (rsp_ready) begin
        rsp_valid <= 1'b0;
      end
    end
  end

endmodule

`default_nettype wire
